>>> hw/rtl/lsbse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsbse_pkg;

  // Default message store depth in bytes
  localparam int unsigned MSG_BYTES_DEF = 4096;

  localparam int unsigned PIXCNT_W  = 25;
  // floor(pixel_count * 3 / 8) fits in one bit fewer than the count
  localparam int unsigned CAP_W     = PIXCNT_W - 1;
  // Capacity for the reset pixel count of 65536: 24576 - 4
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(24572);
  localparam int unsigned HDR_BYTES = 4;
  localparam int unsigned HDR_BITS  = 32;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_EMBED   = 2'd1,
    MODE_EXTRACT = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_BYTE   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  // Result of one extract step
  typedef struct packed {
    logic       got;
    logic [7:0] data;
    logic       last;
  } ext_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/lsbse_extract.sv
`timescale 1ns / 1ps
`default_nettype none

module lsbse_extract (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic               first_i,
  input  wire logic [2:0]         bits_i,
  output lsbse_pkg::ext_res_t     res_o
);
  import lsbse_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] shift_q, shift_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic        got_w, last_w;
  logic [7:0]  byte_w;

  // Three bits per pixel, taken red, green, blue
  always_comb begin : next_state
    phase_e      ph;
    logic [31:0] sh;
    logic [5:0]  cnt;
    logic [31:0] rem;
    ph     = first_i ? PH_HEADER : phase_q;
    sh     = first_i ? '0 : shift_q;
    cnt    = first_i ? '0 : cnt_q;
    rem    = first_i ? '0 : rem_q;
    got_w  = 1'b0;
    last_w = 1'b0;
    byte_w = '0;
    for (int k = 0; k < 3; k++) begin
      case (ph)
        PH_HEADER: begin
          sh  = {sh[30:0], bits_i[k]};
          cnt = cnt + 6'd1;
          if (cnt >= 6'(HDR_BITS)) begin
            rem = sh;
            ph  = (sh == '0) ? PH_DONE : PH_DATA;
            cnt = '0;
            sh  = '0;
          end
        end
        PH_DATA: begin
          sh  = {24'd0, sh[6:0], bits_i[k]};
          cnt = cnt + 6'd1;
          if (cnt >= 6'd8) begin
            byte_w = sh[7:0];
            rem    = rem - 32'd1;
            last_w = (rem == '0);
            if (rem == '0) begin
              ph = PH_DONE;
            end
            cnt   = '0;
            sh    = '0;
            got_w = 1'b1;
          end
        end
        default: ;
      endcase
    end
    phase_d = ph;
    shift_d = sh;
    cnt_d   = cnt;
    rem_d   = rem;
  end

  always_comb begin : outputs
    res_o.got  = step_i & got_w;
    res_o.data = byte_w;
    res_o.last = last_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      shift_q <= '0;
      cnt_q   <= '0;
      rem_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
    end
  end

  a_data_rem_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (rem_q != '0))
    else $error("data phase with no bytes left");

  a_data_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (cnt_q < 6'd8))
    else $error("byte bit count overran");

  a_hdr_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HEADER) |-> (cnt_q < 6'(HDR_BITS)))
    else $error("header bit count overran");

endmodule

`default_nettype wire

>>> hw/rtl/lsb_stego_embed_extract_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    mode_i first_i data_byte_i red_i green_i blue_i alpha_i
// out      out_valid_o / out_ready_i  kind_o out_byte_o last_o red_out_o green_out_o
//                                     blue_out_o alpha_out_o error_o
// cfg      cfg_valid_i / cfg_ready_o  cfg_data_i (pixel_count)
//
// One transaction per clock unless the output stalls; stage 1 and the output are registered.
// The store has two read ports, so a pixel whose three bits span two bytes still
// reads both bytes at once.
// Reset clears counts and sets capacity for 65536 pixels; no clearing pass, as only
// store bytes below the fill count are used.
// Stage 1 acts as a skid slot: input stays ready while one result waits at the output.
// Extract pixels that complete no byte produce no output transaction.

module lsb_stego_embed_extract_unit #(
  parameter int unsigned MSG_BYTES = lsbse_pkg::MSG_BYTES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [1:0]                    mode_i,
  input  wire logic                          first_i,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic [7:0]                    red_i,
  input  wire logic [7:0]                    green_i,
  input  wire logic [7:0]                    blue_i,
  input  wire logic [7:0]                    alpha_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [1:0]                    kind_o,
  output      logic [7:0]                    out_byte_o,
  output      logic                          last_o,
  output      logic [7:0]                    red_out_o,
  output      logic [7:0]                    green_out_o,
  output      logic [7:0]                    blue_out_o,
  output      logic [7:0]                    alpha_out_o,
  output      logic                          error_o,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [lsbse_pkg::PIXCNT_W-1:0] cfg_data_i
);
  import lsbse_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MSG_BYTES);
  localparam int unsigned LEN_W  = $clog2(MSG_BYTES + 1);
  // Stream length in bits is at most (MSG_BYTES + 4) * 8
  localparam int unsigned POS_W  = $clog2((MSG_BYTES + HDR_BYTES) * 8 + 1);
  localparam int unsigned PW1    = POS_W + 1;
  localparam int unsigned CMP_W  = (CAP_W > LEN_W) ? CAP_W : LEN_W;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      data;
    logic            last;
    logic            err;
    logic [2:0][7:0] ch;
    logic [7:0]      alpha;
    logic [2:0]      en;    // bit k carries a stream bit
    logic [2:0]      hdr;   // stream bit comes from the length header
    logic [2:0]      hbit;
    logic [2:0]      sel;   // second store byte
    logic [2:0][2:0] sh;    // bit within store byte
  } s1_t;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      data;
    logic            last;
    logic            err;
    logic [2:0][7:0] ch;
    logic [7:0]      alpha;
  } out_t;

  // Message store, read via two registered read ports
  logic [7:0] mem [MSG_BYTES];
  logic [7:0] rd0_q, rd1_q;

  logic [CAP_W-1:0] cap_q, cap_d;
  logic [LEN_W-1:0] len_q, len_base;
  logic [POS_W-1:0] pos_q, pos_base, pos_d;
  logic             load_ok;

  logic [PW1-1:0]         total;
  logic [2:0][PW1-1:0]    pk;
  logic [ADDR_W-1:0]      rd_addr0, rd_addr1;
  logic [31:0]            hdr_word;

  logic is_load, is_embed, is_extract, has_result;
  logic accept, s1_adv;

  ext_res_t ext_res;

  s1_t  s1_q, s1_n;
  logic s1_valid_q;
  out_t out_q, out_n;
  logic out_valid_q;

  // ---------------------------------------------------------------- handshakes
  assign cfg_ready_o = 1'b1;
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    is_load    = 1'b0;
    is_embed   = 1'b0;
    is_extract = 1'b0;
    case (mode_e'(mode_i))
      MODE_LOAD:    is_load    = 1'b1;
      MODE_EMBED:   is_embed   = 1'b1;
      MODE_EXTRACT: is_extract = 1'b1;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- capacity
  // floor(pixel_count * 3 / 8) - 4, floored at zero; worked out on the write
  always_comb begin
    logic [PIXCNT_W+1:0] triple;
    logic [CAP_W-1:0]    c;
    triple = (PIXCNT_W + 2)'(cfg_data_i) + (PIXCNT_W + 2)'({cfg_data_i, 1'b0});
    c      = triple[PIXCNT_W+1:3];
    cap_d  = (c > CAP_W'(HDR_BYTES)) ? (c - CAP_W'(HDR_BYTES)) : '0;
  end

  // ---------------------------------------------------------------- stage 0
  assign len_base = first_i ? '0 : len_q;
  assign load_ok  = (CMP_W'(len_base) < CMP_W'(cap_q)) && (len_base < LEN_W'(MSG_BYTES));
  assign pos_base = first_i ? '0 : pos_q;
  assign hdr_word = 32'(len_q);
  assign total    = (PW1'(len_q) + PW1'(HDR_BYTES)) << 3;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pk[k] = PW1'(pos_base) + PW1'(k);
    end
    // Three consecutive bits touch at most two stream bytes
    rd_addr0 = ADDR_W'(pos_base[POS_W-1:3] - (POS_W - 3)'(HDR_BYTES));
    rd_addr1 = ADDR_W'(pk[2][PW1-1:3] - (PW1 - 3)'(HDR_BYTES));
  end

  always_comb begin
    s1_n       = '0;
    has_result = 1'b0;
    if (is_load) begin
      has_result = 1'b1;
      s1_n.kind  = KIND_STATUS;
      s1_n.err   = !load_ok;
    end else if (is_embed) begin
      has_result = 1'b1;
      s1_n.kind  = KIND_PIXEL;
      s1_n.ch    = {blue_i, green_i, red_i};
      s1_n.alpha = alpha_i;
      for (int k = 0; k < 3; k++) begin
        s1_n.en[k]   = pk[k] < total;
        s1_n.hdr[k]  = pk[k] < PW1'(HDR_BITS);
        s1_n.hbit[k] = hdr_word[~pk[k][4:0]];
        s1_n.sel[k]  = pk[k][PW1-1:3] != PW1'(pos_base) >> 3;
        s1_n.sh[k]   = ~pk[k][2:0];
      end
    end else if (is_extract) begin
      has_result = ext_res.got;
      s1_n.kind  = KIND_BYTE;
      s1_n.data  = ext_res.data;
      s1_n.last  = ext_res.last;
    end
  end

  // Position stops at the end of the stream
  always_comb begin
    if (s1_n.en[2]) begin
      pos_d = POS_W'(pk[2] + PW1'(1));
    end else if (s1_n.en[1]) begin
      pos_d = POS_W'(pk[2]);
    end else if (s1_n.en[0]) begin
      pos_d = POS_W'(pk[1]);
    end else begin
      pos_d = pos_base;
    end
  end

  lsbse_extract u_extract (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (accept && is_extract),
    .first_i (first_i),
    .bits_i  ({blue_i[0], green_i[0], red_i[0]}),
    .res_o   (ext_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
      len_q <= '0;
      pos_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cap_d;
      end
      if (accept && is_load) begin
        len_q <= load_ok ? (len_base + LEN_W'(1)) : len_base;
      end
      if (accept && is_embed) begin
        pos_q <= pos_d;
      end
    end
  end

  // A load written at one edge is visible to an embed read at the next
  always_ff @(posedge clk_i) begin
    if (accept && is_load && load_ok) begin
      mem[len_base[ADDR_W-1:0]] <= data_byte_i;
    end
    if (accept && is_embed) begin
      rd0_q <= mem[rd_addr0];
      rd1_q <= mem[rd_addr1];
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_comb begin
    logic [7:0] rbyte;
    logic       b;
    out_n.kind  = s1_q.kind;
    out_n.data  = s1_q.data;
    out_n.last  = s1_q.last;
    out_n.err   = s1_q.err;
    out_n.alpha = s1_q.alpha;
    for (int k = 0; k < 3; k++) begin
      rbyte = s1_q.sel[k] ? rd1_q : rd0_q;
      b     = s1_q.hdr[k] ? s1_q.hbit[k] : rbyte[s1_q.sh[k]];
      out_n.ch[k] = {s1_q.ch[k][7:1], s1_q.en[k] ? b : s1_q.ch[k][0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= has_result;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_n;
    end
    if (s1_adv) begin
      out_q <= out_n;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_q.kind;
  assign out_byte_o  = out_q.data;
  assign last_o      = out_q.last;
  assign red_out_o   = out_q.ch[0];
  assign green_out_o = out_q.ch[1];
  assign blue_out_o  = out_q.ch[2];
  assign alpha_out_o = out_q.alpha;
  assign error_o     = out_q.err;

  // ---------------------------------------------------------------- checks
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled with a free slot");

  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_q)))
    else $error("stage 1 lost or changed a held transaction");

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(MSG_BYTES))
    else $error("fill count beyond store depth");

  a_len_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_load && !first_i && load_ok) |=> (len_q == LEN_W'($past(len_q) + 1'b1)))
    else $error("stored byte did not advance fill count");

endmodule

`default_nettype wire

>>> test/tb_lsb_stego_embed_extract_unit.sv
`timescale 1ns / 1ps

module tb_lsb_stego_embed_extract_unit;
  import lsbse_pkg::*;

  localparam int unsigned MSG_DEPTH     = MSG_BYTES_DEF;
  localparam int unsigned RANDOM_ITEMS  = 850;
  // Covers the pass through stage 1 and the output register, with a little margin on top.
  localparam int unsigned SETTLE_CYCLES = 4;
  // Longest quiet spell of a correct run is random idling and stalling plus the
  // settle pause; this is many times that.
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam logic [1:0]  MODE_UNUSED   = 2'd3;
  localparam logic [PIXCNT_W-1:0] PIX_MAX   = PIXCNT_W'(16777216);
  localparam logic [PIXCNT_W-1:0] PIX_RESET = PIXCNT_W'(65536);

  typedef struct packed {
    logic [1:0] mode;
    logic       first;
    logic [7:0] data_byte;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic       last;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       error;
  } px_result_t;

  // How a table row is checked: by the predictor, against a typed-in result,
  // as an item that must give nothing, or a register write.
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_TYPED,
    ROW_SILENT,
    ROW_CONFIG
  } row_kind_e;

  typedef struct packed {
    row_kind_e           rk;
    logic [7:0]          rep;
    pix_item_t           it;
    logic [PIXCNT_W-1:0] cfg;
    px_result_t          want;
  } dir_row_t;

  localparam px_result_t NO_RESULT =
    '{KIND_STATUS, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0};
  localparam px_result_t LOAD_OK   =
    '{KIND_STATUS, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0};
  localparam px_result_t LOAD_DROP =
    '{KIND_STATUS, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1};

  localparam int unsigned DIR_ROWS = 17;
  // Runs from reset (65536 pixels), so a two-byte message fits easily.
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{ROW_TYPED,   8'd1, '{MODE_LOAD,    1'b1, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF},
      '0, LOAD_OK},
    '{ROW_TYPED,   8'd1, '{MODE_LOAD,    1'b0, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00},
      '0, LOAD_OK},
    // unused mode: no transaction out, no state touched
    '{ROW_SILENT,  8'd1, '{MODE_UNUSED,  1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '0, NO_RESULT},
    // header of a length-2 message starts with zero bits
    '{ROW_TYPED,   8'd1, '{MODE_EMBED,   1'b1, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '0, '{KIND_PIXEL, 8'h00, 1'b0, 8'hFE, 8'hFE, 8'hFE, 8'hFF, 1'b0}},
    '{ROW_TYPED,   8'd1, '{MODE_EMBED,   1'b0, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00},
      '0, '{KIND_PIXEL, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0}},
    '{ROW_PREDICT, 8'd1, '{MODE_EMBED,   1'b0, 8'h00, 8'hA5, 8'h5A, 8'hC3, 8'h3C},
      '0, NO_RESULT},
    // header still incomplete: no byte yet
    '{ROW_SILENT,  8'd1, '{MODE_EXTRACT, 1'b1, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '0, NO_RESULT},
    '{ROW_SILENT,  8'd1, '{MODE_EXTRACT, 1'b0, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00},
      '0, NO_RESULT},
    // no capacity at all: every load is dropped
    '{ROW_CONFIG,  8'd0, '0, '0, NO_RESULT},
    '{ROW_TYPED,   8'd1, '{MODE_LOAD,    1'b1, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h00},
      '0, LOAD_DROP},
    '{ROW_TYPED,   8'd1, '{MODE_LOAD,    1'b0, 8'hA5, 8'h00, 8'h00, 8'h00, 8'h00},
      '0, LOAD_DROP},
    // all-zero header: empty message goes straight to done, later pixels ignored
    '{ROW_PREDICT, 8'd11, '{MODE_EXTRACT, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '0, NO_RESULT},
    '{ROW_SILENT,  8'd2, '{MODE_EXTRACT, 1'b0, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '0, NO_RESULT},
    // 14 pixels give room for exactly one byte
    '{ROW_CONFIG,  8'd0, '0, PIXCNT_W'(14), NO_RESULT},
    '{ROW_TYPED,   8'd1, '{MODE_LOAD,    1'b1, 8'hC3, 8'h00, 8'h00, 8'h00, 8'h00},
      '0, LOAD_OK},
    '{ROW_TYPED,   8'd1, '{MODE_LOAD,    1'b0, 8'h3C, 8'h00, 8'h00, 8'h00, 8'h00},
      '0, LOAD_DROP},
    '{ROW_CONFIG,  8'd0, '0, PIX_MAX, NO_RESULT}
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [1:0]          mode_i      = '0;
  logic                first_i     = 1'b0;
  logic [7:0]          data_byte_i = '0;
  logic [7:0]          red_i       = '0;
  logic [7:0]          green_i     = '0;
  logic [7:0]          blue_i      = '0;
  logic [7:0]          alpha_i     = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [1:0]          kind_o;
  logic [7:0]          out_byte_o;
  logic                last_o;
  logic [7:0]          red_out_o;
  logic [7:0]          green_out_o;
  logic [7:0]          blue_out_o;
  logic [7:0]          alpha_out_o;
  logic                error_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [PIXCNT_W-1:0] cfg_data_i  = '0;

  lsb_stego_embed_extract_unit #(
    .MSG_BYTES(MSG_DEPTH)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .first_i     (first_i),
    .data_byte_i (data_byte_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .alpha_i     (alpha_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .alpha_out_o (alpha_out_o),
    .error_o     (error_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: message store, fill count, embed position and the
  // extraction shifter with its phase.
  // ---------------------------------------------------------------------------
  logic [7:0]          msg_store [MSG_DEPTH];
  int unsigned         msg_len   = 0;
  int unsigned         emb_pos   = 0;
  logic [31:0]         ext_shift = '0;
  int unsigned         ext_cnt   = 0;
  logic [31:0]         ext_rem   = '0;
  phase_e              ext_phase = PH_HEADER;
  logic [PIXCNT_W-1:0] pix_count = PIX_RESET;

  px_result_t  expected_q [$];
  px_result_t  last_res;
  int unsigned n_counted = 0;
  int unsigned n_errors  = 0;
  int unsigned stall_cycles = 0;
  bit          calm = 1'b0;     // no idling on either side while set

  // Bytes the cover image can carry beyond the 4-byte length header.
  function automatic longint unsigned capacity_bytes();
    longint unsigned c;
    c = (64'(pix_count) * 3) / 8;
    return (c <= 4) ? 0 : c - 4;
  endfunction

  // Bit of the header-plus-message stream, MSB first within each byte.
  function automatic logic stream_bit(input int unsigned pos);
    int unsigned idx;
    logic [31:0] len32;
    logic [7:0]  b;
    idx   = pos >> 3;
    len32 = msg_len;
    if (idx < HDR_BYTES) b = len32[8*(3-idx) +: 8];
    else                 b = msg_store[idx-HDR_BYTES];
    return b[7 - (pos & 7)];
  endfunction

  task automatic predict_item(input pix_item_t it, output bit got, output px_result_t r);
    logic [7:0]  ch [3];
    int unsigned total;
    logic        bitv;
    int          k;
    r      = NO_RESULT;
    got    = 1'b0;
    ch[0]  = it.red;
    ch[1]  = it.green;
    ch[2]  = it.blue;
    case (it.mode)
      MODE_LOAD: begin
        got = 1'b1;
        if (it.first) msg_len = 0;
        if (msg_len < capacity_bytes() && msg_len < MSG_DEPTH) begin
          msg_store[msg_len] = it.data_byte;
          msg_len++;
        end else begin
          r.error = 1'b1;
        end
      end
      MODE_EMBED: begin
        total = (HDR_BYTES + msg_len) * 8;
        if (it.first) emb_pos = 0;
        for (k = 0; k < 3; k++) begin
          if (emb_pos < total) begin
            ch[k][0] = stream_bit(emb_pos);
            emb_pos++;
          end
        end
        got     = 1'b1;
        r.kind  = KIND_PIXEL;
        r.red   = ch[0];
        r.green = ch[1];
        r.blue  = ch[2];
        r.alpha = it.alpha;
      end
      MODE_EXTRACT: begin
        if (it.first) begin
          ext_shift = '0;
          ext_cnt   = 0;
          ext_rem   = '0;
          ext_phase = PH_HEADER;
        end
        for (k = 0; k < 3; k++) begin
          bitv = ch[k][0];
          if (ext_phase == PH_HEADER) begin
            ext_shift = {ext_shift[30:0], bitv};
            ext_cnt++;
            if (ext_cnt == HDR_BITS) begin
              ext_rem   = ext_shift;
              ext_phase = (ext_rem == 0) ? PH_DONE : PH_DATA;
              ext_cnt   = 0;
              ext_shift = '0;
            end
          end else if (ext_phase == PH_DATA) begin
            ext_shift = {24'd0, ext_shift[6:0], bitv};
            ext_cnt++;
            if (ext_cnt == 8) begin
              got        = 1'b1;
              r.kind     = KIND_BYTE;
              r.out_byte = ext_shift[7:0];
              ext_rem    = ext_rem - 1;
              r.last     = (ext_rem == 0);
              if (ext_rem == 0) ext_phase = PH_DONE;
              ext_cnt    = 0;
              ext_shift  = '0;
            end
          end
        end
      end
      default: ;  // unused mode is ignored
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sender. Valid is left high after a transaction; the next call either idles
  // (lowering it) or presents the next item, so valid never drops and rises in
  // one step.
  // ---------------------------------------------------------------------------
  task automatic send_item(input pix_item_t it, input row_kind_e rk, input px_result_t want);
    bit         got;
    px_result_t r;
    while (!calm && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= it.mode;
    first_i     <= it.first;
    data_byte_i <= it.data_byte;
    red_i       <= it.red;
    green_i     <= it.green;
    blue_i      <= it.blue;
    alpha_i     <= it.alpha;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_item(it, got, r);
    if (rk == ROW_TYPED)                expected_q.push_back(want);
    else if (rk == ROW_PREDICT && got)  expected_q.push_back(r);
    last_res = r;
    if (it.mode != MODE_UNUSED) n_counted++;
  endtask

  // Hold the input off until every expected result is out and the pipe is quiet.
  task automatic pause_input();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_pixel_count(input logic [PIXCNT_W-1:0] v);
    pause_input();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    pix_count = v;
  endtask

  function automatic pix_item_t random_item(input logic [1:0] mode);
    pix_item_t it;
    it.mode      = mode;
    it.first     = 1'($urandom);
    it.data_byte = 8'($urandom);
    it.red       = 8'($urandom);
    it.green     = 8'($urandom);
    it.blue      = 8'($urandom);
    it.alpha     = 8'($urandom);
    return it;
  endfunction

  function automatic logic [PIXCNT_W-1:0] pick_pixel_count();
    case ($urandom_range(6))
      0:       return '0;
      1:       return PIXCNT_W'($urandom_range(1, 13));
      2:       return PIXCNT_W'(14);
      3:       return PIXCNT_W'($urandom_range(15, 400));
      4:       return PIX_RESET;
      5:       return PIX_MAX;
      default: return PIXCNT_W'($urandom_range(401, 16777216));
    endcase
  endfunction

  // Load a message, embed it over enough pixels (plus a few past the stream),
  // then feed the stego pixels back for extraction.
  task automatic run_session(input int unsigned n_load, input int unsigned n_extra);
    pix_item_t   it;
    pix_item_t   stego_q [$];
    int unsigned n_pix;
    for (int unsigned i = 0; i < n_load; i++) begin
      it       = random_item(MODE_LOAD);
      it.first = (i == 0);
      send_item(it, ROW_PREDICT, NO_RESULT);
    end
    n_pix = ((HDR_BYTES + msg_len) * 8 + 2) / 3 + n_extra;
    for (int unsigned i = 0; i < n_pix; i++) begin
      it       = random_item(MODE_EMBED);
      it.first = (i == 0);
      send_item(it, ROW_PREDICT, NO_RESULT);
      it.mode  = MODE_EXTRACT;
      it.red   = last_res.red;
      it.green = last_res.green;
      it.blue  = last_res.blue;
      it.alpha = last_res.alpha;
      stego_q.push_back(it);
    end
    foreach (stego_q[i]) send_item(stego_q[i], ROW_PREDICT, NO_RESULT);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------
  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, seen);
      n_errors++;
    end
  endtask

  px_result_t exp_r;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d byte %0h",
                 $time, kind_o, out_byte_o);
        n_errors++;
      end else begin
        exp_r = expected_q.pop_front();
        check_field("kind",      8'(exp_r.kind), 8'(kind_o));
        check_field("out_byte",  exp_r.out_byte, out_byte_o);
        check_field("last",      8'(exp_r.last), 8'(last_o));
        check_field("red_out",   exp_r.red,      red_out_o);
        check_field("green_out", exp_r.green,    green_out_o);
        check_field("blue_out",  exp_r.blue,     blue_out_o);
        check_field("alpha_out", exp_r.alpha,    alpha_out_o);
        check_field("error",     8'(exp_r.error), 8'(error_o));
      end
    end
    out_ready_i <= calm || ($urandom_range(99) >= 19);
  end

  // Watchdog: too long without any transaction on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
      $display("[lsb_stego_embed_extract_unit] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    pix_item_t   it;
    int unsigned sel;
    int unsigned n_load;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TAB[i].rk == ROW_CONFIG) begin
        set_pixel_count(DIR_TAB[i].cfg);
      end else begin
        for (int k = 0; k < DIR_TAB[i].rep; k++) begin
          it = DIR_TAB[i].it;
          if (k != 0) it.first = 1'b0;
          send_item(it, DIR_TAB[i].rk, DIR_TAB[i].want);
        end
      end
    end

    // Long stretch with no idling on either side: load a short message,
    // embed it and read it back.
    calm = 1'b1;
    run_session(24, 3);
    calm = 1'b0;

    while (n_counted < RANDOM_ITEMS) begin
      sel = $urandom_range(99);
      if (sel < 35)      set_pixel_count(pick_pixel_count());
      else if (sel < 45) pause_input();

      sel    = $urandom_range(99);
      n_load = (sel < 10) ? 0 : (sel < 85) ? $urandom_range(1, 12) : $urandom_range(13, 60);
      run_session(n_load, $urandom_range(4));

      // broken extraction: random lsbs give arbitrary, mostly huge, counts
      if ($urandom_range(99) < 25) begin
        sel = $urandom_range(12, 40);
        for (int unsigned i = 0; i < sel; i++) begin
          it       = random_item(MODE_EXTRACT);
          it.first = (i == 0);
          send_item(it, ROW_PREDICT, NO_RESULT);
        end
      end

      repeat ($urandom_range(10)) begin
        it       = random_item(2'($urandom));
        it.first = ($urandom_range(3) == 0);
        send_item(it, ROW_PREDICT, NO_RESULT);
      end
    end

    pause_input();
    if (n_errors == 0) begin
      $display("[lsb_stego_embed_extract_unit] OK");
    end else begin
      $display("[lsb_stego_embed_extract_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/lsbse_pkg.sv
hw/rtl/lsbse_extract.sv
hw/rtl/lsb_stego_embed_extract_unit.sv
test/tb_lsb_stego_embed_extract_unit.sv
